[sv/sva_pkg.sv]
package sva_pkg;

  localparam int DEF_NUM_VOICES = 8;
  localparam int DEF_NUM_TAILS = 4;
  localparam int DEF_FADE_LEN = 64;
  localparam int DEF_PAD_COUNT = 16;

  localparam int CMD_W = 3;
  localparam int PAD_W = 4;
  localparam int RATE_W = 18;
  localparam int FRAME_W = 24;
  localparam int SPEED_W = 16;
  localparam int SLOT_W = 3;
  localparam int FRAMES_W = 11;
  localparam int VOICE_OUT_W = 3;
  localparam int TSLOT_OUT_W = 2;
  localparam int COUNT_W = 32;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [SPEED_W-1:0] MIN_SPEED_RST = 16'd1024;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd16384;
  localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = 18'd48000;

  typedef enum logic [CMD_W-1:0] {
    CMD_TRIGGER   = 3'd0,
    CMD_SET_SPEED = 3'd1,
    CMD_STOP_PAD  = 3'd2,
    CMD_STOP_ALL  = 3'd3,
    CMD_QUERY     = 3'd4,
    CMD_VOICE_END = 3'd5,
    CMD_TAIL_END  = 3'd6,
    CMD_TICK      = 3'd7
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SPEED   = 2'd0,
    REG_MAX_SPEED   = 2'd1,
    REG_OUTPUT_RATE = 2'd2
  } reg_e;

  typedef struct packed {
    logic load;
    logic check;
    logic tscan;
    logic vscan;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic tail_last;
    logic voice_last;
  } status_t;

endpackage

[sv/sva_in_if.sv]
interface sva_in_if;
  logic                          valid;
  logic                          ready;
  logic [sva_pkg::CMD_W-1:0]     cmd;
  logic [sva_pkg::PAD_W-1:0]     pad;
  logic                          sample_valid;
  logic [sva_pkg::RATE_W-1:0]    source_rate;
  logic [sva_pkg::FRAME_W-1:0]   start_frame;
  logic [sva_pkg::FRAME_W-1:0]   end_frame;
  logic [sva_pkg::FRAME_W-1:0]   frame_total;
  logic [sva_pkg::SPEED_W-1:0]   user_speed;
  logic [sva_pkg::SLOT_W-1:0]    slot;
  logic [sva_pkg::FRAMES_W-1:0]  frames;

  modport source (
    output valid, cmd, pad, sample_valid, source_rate, start_frame, end_frame,
           frame_total, user_speed, slot, frames,
    input  ready
  );
  modport sink (
    input  valid, cmd, pad, sample_valid, source_rate, start_frame, end_frame,
           frame_total, user_speed, slot, frames,
    output ready
  );
endinterface

[sv/sva_out_if.sv]
interface sva_out_if;
  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic [sva_pkg::VOICE_OUT_W-1:0]   voice;
  logic                              stolen;
  logic [sva_pkg::TSLOT_OUT_W-1:0]   tail_slot;
  logic                              tail_used;
  logic                              tail_dropped;
  logic                              pad_playing;

  modport source (
    output valid, accepted, voice, stolen, tail_slot, tail_used, tail_dropped,
           pad_playing,
    input  ready
  );
  modport sink (
    input  valid, accepted, voice, stolen, tail_slot, tail_used, tail_dropped,
           pad_playing,
    output ready
  );
endinterface

[sv/sva_cfg_if.sv]
interface sva_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sva_pkg::CFG_IDX_W-1:0]    index;
  logic [sva_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/sampler_voice_allocator_unit.sv]
// A request is registered, checked, run through the tail scan and voice scan, which
// visit one slot per cycle, and committed; a new request is taken only when idle again.
// The result register lets the next request start while a result waits.
// Reset is synchronous and active high: all voices and tails free, registers at defaults.
module sampler_voice_allocator_unit #(
  parameter int NUM_VOICES = sva_pkg::DEF_NUM_VOICES,
  parameter int NUM_TAILS  = sva_pkg::DEF_NUM_TAILS,
  parameter int FADE_LEN   = sva_pkg::DEF_FADE_LEN,
  parameter int PAD_COUNT  = sva_pkg::DEF_PAD_COUNT
) (
  input logic       clk,
  input logic       rst,
  sva_in_if.sink    items,
  sva_out_if.source results,
  sva_cfg_if.sink   cfg
);

  sva_pkg::ctl_t    ctl;
  sva_pkg::status_t st;

  assign cfg.ready = 1'b1;

  sva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .ctl       (ctl),
    .st        (st)
  );

  sva_datapath #(
    .NUM_VOICES (NUM_VOICES),
    .NUM_TAILS  (NUM_TAILS),
    .FADE_LEN   (FADE_LEN),
    .PAD_COUNT  (PAD_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .st               (st),
    .cfg_we           (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .cmd              (items.cmd),
    .pad              (items.pad),
    .sample_valid     (items.sample_valid),
    .source_rate      (items.source_rate),
    .start_frame      (items.start_frame),
    .end_frame        (items.end_frame),
    .frame_total      (items.frame_total),
    .user_speed       (items.user_speed),
    .slot             (items.slot),
    .frames           (items.frames),
    .res_accepted     (results.accepted),
    .res_voice        (results.voice),
    .res_stolen       (results.stolen),
    .res_tail_slot    (results.tail_slot),
    .res_tail_used    (results.tail_used),
    .res_tail_dropped (results.tail_dropped),
    .res_pad_playing  (results.pad_playing)
  );

endmodule

[sv/sva_ctrl.sv]
module sva_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sva_pkg::ctl_t     ctl,
  input  sva_pkg::status_t  st
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    TSCAN,
    VSCAN,
    COMMIT
  } state_t;

  state_t state;

  always_comb begin
    in_ready   = (state == IDLE);
    ctl.load   = (state == IDLE) && in_valid;
    ctl.check  = (state == CHECK);
    ctl.tscan  = (state == TSCAN);
    ctl.vscan  = (state == VSCAN);
    ctl.commit = (state == COMMIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (ctl.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_valid) begin
            state <= CHECK;
          end
        end
        CHECK: begin
          state <= TSCAN;
        end
        TSCAN: begin
          if (st.tail_last) begin
            state <= VSCAN;
          end
        end
        VSCAN: begin
          if (st.voice_last) begin
            state <= COMMIT;
          end
        end
        COMMIT: begin
          if (!out_valid || out_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_tail_to_voice: assert property (@(posedge clk) disable iff (rst)
    (state == TSCAN) && st.tail_last |=> (state == VSCAN))
    else $error("tail scan did not hand over to voice scan");
`endif

endmodule

[sv/sva_datapath.sv]
module sva_datapath #(
  parameter int NUM_VOICES = sva_pkg::DEF_NUM_VOICES,
  parameter int NUM_TAILS  = sva_pkg::DEF_NUM_TAILS,
  parameter int FADE_LEN   = sva_pkg::DEF_FADE_LEN,
  parameter int PAD_COUNT  = sva_pkg::DEF_PAD_COUNT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sva_pkg::ctl_t                      ctl,
  output sva_pkg::status_t                   st,
  input  logic                               cfg_we,
  input  logic [sva_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sva_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [sva_pkg::CMD_W-1:0]          cmd,
  input  logic [sva_pkg::PAD_W-1:0]          pad,
  input  logic                               sample_valid,
  input  logic [sva_pkg::RATE_W-1:0]         source_rate,
  input  logic [sva_pkg::FRAME_W-1:0]        start_frame,
  input  logic [sva_pkg::FRAME_W-1:0]        end_frame,
  input  logic [sva_pkg::FRAME_W-1:0]        frame_total,
  input  logic [sva_pkg::SPEED_W-1:0]        user_speed,
  input  logic [sva_pkg::SLOT_W-1:0]         slot,
  input  logic [sva_pkg::FRAMES_W-1:0]       frames,
  output logic                               res_accepted,
  output logic [sva_pkg::VOICE_OUT_W-1:0]    res_voice,
  output logic                               res_stolen,
  output logic [sva_pkg::TSLOT_OUT_W-1:0]    res_tail_slot,
  output logic                               res_tail_used,
  output logic                               res_tail_dropped,
  output logic                               res_pad_playing
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int TW = (NUM_TAILS > 1) ? $clog2(NUM_TAILS) : 1;
  localparam int FW = $clog2(FADE_LEN + 1);
  localparam int AW = ((FW > sva_pkg::FRAMES_W) ? FW : sva_pkg::FRAMES_W) + 1;
  localparam int CW = sva_pkg::COUNT_W;
  localparam logic [FW-1:0] FADE_FULL = FW'(FADE_LEN);

  function automatic logic [FW-1:0] advance(input logic [FW-1:0] f,
                                            input logic [sva_pkg::FRAMES_W-1:0] n);
    logic [AW-1:0] rem;
    logic [AW-1:0] step;
    rem  = (AW'(f) < AW'(FADE_LEN)) ? (AW'(FADE_LEN) - AW'(f)) : '0;
    step = (AW'(n) < rem) ? AW'(n) : rem;
    return FW'(AW'(f) + step);
  endfunction

  // Configuration registers.
  logic [sva_pkg::SPEED_W-1:0] min_speed;
  logic [sva_pkg::SPEED_W-1:0] max_speed;
  logic [sva_pkg::RATE_W-1:0]  output_rate;

  // Registered request.
  sva_pkg::cmd_e                 cmd_q;
  logic [sva_pkg::PAD_W-1:0]     pad_q;
  logic                          svalid_q;
  logic [sva_pkg::RATE_W-1:0]    srate_q;
  logic [sva_pkg::FRAME_W-1:0]   sframe_q;
  logic [sva_pkg::FRAME_W-1:0]   eframe_q;
  logic [sva_pkg::FRAME_W-1:0]   total_q;
  logic [sva_pkg::SPEED_W-1:0]   speed_q;
  logic [sva_pkg::SLOT_W-1:0]    slot_q;
  logic [sva_pkg::FRAMES_W-1:0]  frames_q;
  logic                          trig_ok;
  logic                          spd_ok;

  // Voice and tail state.
  logic [NUM_VOICES-1:0]         voice_busy;
  logic [sva_pkg::PAD_W-1:0]     voice_pad   [NUM_VOICES];
  logic [CW-1:0]                 voice_age   [NUM_VOICES];
  logic [FW-1:0]                 voice_fade  [NUM_VOICES];
  logic [NUM_TAILS-1:0]          tail_active;
  logic [sva_pkg::PAD_W-1:0]     tail_out_pad [NUM_TAILS];
  logic [sva_pkg::PAD_W-1:0]     tail_in_pad  [NUM_TAILS];
  logic [FW-1:0]                 tail_fade    [NUM_TAILS];
  logic [CW-1:0]                 tail_serial  [NUM_TAILS];
  logic [CW-1:0]                 age_count;
  logic [CW-1:0]                 serial_count;

  // Scan counters and scan results.
  logic [TW-1:0]                 tidx;
  logic [VW-1:0]                 vidx;
  logic                          t_free_found;
  logic [TW-1:0]                 t_free_idx;
  logic [TW-1:0]                 t_min_idx;
  logic [CW-1:0]                 t_min_serial;
  logic                          v_match_found;
  logic [VW-1:0]                 v_match_idx;
  logic                          v_free_found;
  logic [VW-1:0]                 v_free_idx;
  logic [VW-1:0]                 v_old_idx;
  logic [CW-1:0]                 v_old_age;
  logic [sva_pkg::PAD_W-1:0]     v_old_pad;
  logic                          playing;

  logic                          spd_ok_c;
  logic                          trig_ok_c;
  logic                          t_hit;
  logic                          t_slot_hit;
  logic                          t_eff_active;
  logic [FW-1:0]                 t_adv;
  logic                          v_match;
  logic                          v_slot_hit;
  logic                          v_freed;
  logic [FW-1:0]                 v_adv;
  logic                          do_trig;
  logic                          stolen_c;
  logic                          spd_acc;
  logic [VW-1:0]                 v_sel;
  logic [TW-1:0]                 t_sel;

  always_comb begin
    spd_ok_c  = (speed_q != '0) && (speed_q >= min_speed) && (speed_q <= max_speed) &&
                (32'(pad_q) < PAD_COUNT);
    trig_ok_c = spd_ok_c && svalid_q && (sframe_q < eframe_q) && (eframe_q <= total_q) &&
                (output_rate != '0) && (srate_q != '0);

    st.tail_last  = (tidx == TW'(NUM_TAILS - 1));
    st.voice_last = (vidx == VW'(NUM_VOICES - 1));

    t_hit        = tail_active[tidx] &&
                   ((tail_out_pad[tidx] == pad_q) || (tail_in_pad[tidx] == pad_q));
    t_slot_hit   = (32'(slot_q) == 32'(tidx));
    t_eff_active = tail_active[tidx] && !(trig_ok && t_hit);
    t_adv        = advance(tail_fade[tidx], frames_q);

    v_match    = voice_busy[vidx] && (voice_pad[vidx] == pad_q);
    v_slot_hit = (32'(slot_q) == 32'(vidx));
    v_adv      = advance(voice_fade[vidx], frames_q);
    case (cmd_q)
      sva_pkg::CMD_STOP_PAD:  v_freed = v_match;
      sva_pkg::CMD_STOP_ALL:  v_freed = 1'b1;
      sva_pkg::CMD_VOICE_END: v_freed = v_slot_hit;
      default:                v_freed = 1'b0;
    endcase

    do_trig  = (cmd_q == sva_pkg::CMD_TRIGGER) && trig_ok;
    stolen_c = !v_match_found && !v_free_found;
    spd_acc  = (cmd_q == sva_pkg::CMD_SET_SPEED) && spd_ok && v_match_found;
    v_sel    = v_match_found ? v_match_idx : (v_free_found ? v_free_idx : v_old_idx);
    t_sel    = t_free_found ? t_free_idx : t_min_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_speed    <= sva_pkg::MIN_SPEED_RST;
      max_speed    <= sva_pkg::MAX_SPEED_RST;
      output_rate  <= sva_pkg::OUTPUT_RATE_RST;
      voice_busy   <= '0;
      tail_active  <= '0;
      age_count    <= '0;
      serial_count <= '0;
      tidx         <= '0;
      vidx         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sva_pkg::REG_MIN_SPEED:   min_speed   <= cfg_data[sva_pkg::SPEED_W-1:0];
          sva_pkg::REG_MAX_SPEED:   max_speed   <= cfg_data[sva_pkg::SPEED_W-1:0];
          sva_pkg::REG_OUTPUT_RATE: output_rate <= cfg_data[sva_pkg::RATE_W-1:0];
          default: ;
        endcase
      end

      if (ctl.load) begin
        cmd_q    <= sva_pkg::cmd_e'(cmd);
        pad_q    <= pad;
        svalid_q <= sample_valid;
        srate_q  <= source_rate;
        sframe_q <= start_frame;
        eframe_q <= end_frame;
        total_q  <= frame_total;
        speed_q  <= user_speed;
        slot_q   <= slot;
        frames_q <= frames;
      end

      if (ctl.check) begin
        trig_ok       <= trig_ok_c;
        spd_ok        <= spd_ok_c;
        tidx          <= '0;
        vidx          <= '0;
        t_free_found  <= 1'b0;
        v_match_found <= 1'b0;
        v_free_found  <= 1'b0;
        playing       <= 1'b0;
      end

      if (ctl.tscan) begin
        case (cmd_q)
          sva_pkg::CMD_TRIGGER: begin
            if (trig_ok && t_hit) begin
              tail_active[tidx] <= 1'b0;
              tail_fade[tidx]   <= FADE_FULL;
            end
          end
          sva_pkg::CMD_STOP_PAD: begin
            if (t_hit) begin
              tail_active[tidx] <= 1'b0;
              tail_fade[tidx]   <= FADE_FULL;
            end
          end
          sva_pkg::CMD_STOP_ALL: begin
            tail_active[tidx] <= 1'b0;
            tail_fade[tidx]   <= FADE_FULL;
          end
          sva_pkg::CMD_TAIL_END: begin
            if (t_slot_hit) begin
              tail_active[tidx] <= 1'b0;
            end
          end
          sva_pkg::CMD_TICK: begin
            if ((frames_q != '0) && tail_active[tidx]) begin
              tail_fade[tidx] <= t_adv;
              if (t_adv >= FADE_FULL) begin
                tail_active[tidx] <= 1'b0;
              end
            end
          end
          default: ;
        endcase
        if (!t_eff_active && !t_free_found) begin
          t_free_found <= 1'b1;
          t_free_idx   <= tidx;
        end
        if ((tidx == '0) || (tail_serial[tidx] < t_min_serial)) begin
          t_min_idx    <= tidx;
          t_min_serial <= tail_serial[tidx];
        end
        tidx <= st.tail_last ? '0 : tidx + 1'b1;
      end

      if (ctl.vscan) begin
        case (cmd_q)
          sva_pkg::CMD_STOP_PAD: begin
            if (v_match) begin
              voice_busy[vidx] <= 1'b0;
              voice_fade[vidx] <= FADE_FULL;
            end
          end
          sva_pkg::CMD_STOP_ALL: begin
            voice_busy[vidx] <= 1'b0;
            voice_fade[vidx] <= FADE_FULL;
          end
          sva_pkg::CMD_VOICE_END: begin
            if (v_slot_hit) begin
              voice_busy[vidx] <= 1'b0;
            end
          end
          sva_pkg::CMD_TICK: begin
            if ((frames_q != '0) && voice_busy[vidx]) begin
              voice_fade[vidx] <= v_adv;
            end
          end
          default: ;
        endcase
        if (v_match && !v_match_found) begin
          v_match_found <= 1'b1;
          v_match_idx   <= vidx;
        end
        if (!voice_busy[vidx] && !v_free_found) begin
          v_free_found <= 1'b1;
          v_free_idx   <= vidx;
        end
        if ((vidx == '0) || (voice_age[vidx] < v_old_age)) begin
          v_old_idx <= vidx;
          v_old_age <= voice_age[vidx];
          v_old_pad <= voice_pad[vidx];
        end
        playing <= playing | (v_match && !v_freed);
        vidx <= st.voice_last ? '0 : vidx + 1'b1;
      end

      if (ctl.commit) begin
        if (do_trig) begin
          voice_busy[v_sel] <= 1'b1;
          voice_pad[v_sel]  <= pad_q;
          voice_age[v_sel]  <= age_count;
          voice_fade[v_sel] <= stolen_c ? '0 : FADE_FULL;
          age_count         <= age_count + 1'b1;
          if (stolen_c) begin
            tail_active[t_sel]  <= 1'b1;
            tail_out_pad[t_sel] <= v_old_pad;
            tail_in_pad[t_sel]  <= pad_q;
            tail_fade[t_sel]    <= '0;
            tail_serial[t_sel]  <= serial_count;
            serial_count        <= serial_count + 1'b1;
          end
        end
        res_accepted     <= do_trig || spd_acc;
        res_voice        <= do_trig ? sva_pkg::VOICE_OUT_W'(v_sel) :
                            (spd_acc ? sva_pkg::VOICE_OUT_W'(v_match_idx) : '0);
        res_stolen       <= do_trig && stolen_c;
        res_tail_slot    <= (do_trig && stolen_c) ? sva_pkg::TSLOT_OUT_W'(t_sel) : '0;
        res_tail_used    <= do_trig && stolen_c;
        res_tail_dropped <= do_trig && stolen_c && !t_free_found;
        res_pad_playing  <= do_trig || playing;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_steal_only_full: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && do_trig && stolen_c |-> ($countones(voice_busy) == NUM_VOICES))
    else $error("voice stolen while a voice was free");
  a_trigger_plays: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && do_trig |=> res_pad_playing && voice_busy[$past(v_sel)])
    else $error("accepted trigger left its voice idle");
  a_tail_taken: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && do_trig && stolen_c |=> tail_active[$past(t_sel)] && res_tail_used)
    else $error("stolen voice did not occupy a tail slot");
`endif

endmodule
